// File: hdl/dag_longest_path_kahn_core_macros.svh
// ----------------------------------------------------------------------------
// DAG longest path core - assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DAG_LONGEST_PATH_KAHN_CORE_MACROS_SVH
`define DAG_LONGEST_PATH_KAHN_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DLPK_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define DLPK_CHECK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/dlpk_pkg.sv
// ----------------------------------------------------------------------------
// DAG longest path core - package
// Field widths, register codes, defaults and shared types.
// ----------------------------------------------------------------------------
package dlpk_pkg;

    localparam int VERTEX_FIELD_W = 10;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int VCOUNT_W       = 11;
    localparam int VISIT_W        = 11;
    localparam int DIST_W         = 26;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 40;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 11;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam logic [VCOUNT_W-1:0]       VCOUNT_RESET = 11'd1024;
    localparam logic [VERTEX_FIELD_W-1:0] SINK_RESET   = 10'd1023;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SINK_VERTEX  = 2'd1;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } queue_ctrl_t;

endpackage

// File: hdl/dlpk_queue.sv
// ----------------------------------------------------------------------------
// DAG longest path core - ready queue
// FIFO of ready vertices in one memory; pop data arrives in the cycle after the pop.
// ----------------------------------------------------------------------------
module dlpk_queue #(
    parameter int DEPTH = dlpk_pkg::MAX_VERTICES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dlpk_pkg::queue_ctrl_t ctrl,
    input  logic [AW-1:0]        push_data,
    output logic [AW-1:0]        rd_data,
    output logic [CW-1:0]        head,
    output logic [CW-1:0]        tail
);

    logic [AW-1:0] mem [DEPTH];
    logic [CW-1:0] head_reg;
    logic [CW-1:0] tail_reg;
    logic [AW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[tail_reg[AW-1:0]] <= push_data;
        end
        rd_data_reg <= mem[head_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            if (ctrl.push) begin
                tail_reg <= tail_reg + CW'(1);
            end
            if (ctrl.pop) begin
                head_reg <= head_reg + CW'(1);
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign head    = head_reg;
    assign tail    = tail_reg;

endmodule

// File: hdl/dag_longest_path_kahn_core.sv
// ----------------------------------------------------------------------------
// DAG longest path core - top level
// Loads a weighted edge list, then runs a Kahn walk and reports the longest
// distance to the sink vertex, a cycle flag and the visited vertex count.
// ----------------------------------------------------------------------------
// Each edge item is taken in ST_IDLE, which reads the source's list head and
// the target's in-degree, then ST_LOAD_WR writes the edge and updates both.
// The item with tlast then starts the walk: a scan over the in-degree memory,
// then per visited vertex a queue read, a vertex read and a list check, and
// per out-edge an edge read, a target read and a write back. One result item
// then goes out, after which a clearing pass over all MAX_VERTICES entries
// (also run once after reset) wipes the vertex memories; no edge item is
// taken meanwhile.
// Configuration is taken at any time and must only be written while idle.
module dag_longest_path_kahn_core #(
    parameter int MAX_VERTICES = dlpk_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = dlpk_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = dlpk_pkg::WEIGHT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // edge items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // from_vertex[9:0], to_vertex[19:10], edge_weight[35:20], zero pad
    input  logic [dlpk_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,     // last_edge
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // longest_to_sink[25:0], cycle_found[26], visited_count[37:27], zero pad
    output logic [dlpk_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dlpk_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dlpk_pkg::CFG_DATA_W-1:0]    cfg_data
);

    `include "dag_longest_path_kahn_core_macros.svh"

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LW  = EIW + 1;     // edge links, edge count, in-degree
    localparam int DW  = dlpk_pkg::DIST_W;
    localparam int SW  = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD_WR, ST_SCAN, ST_POP, ST_POP_WAIT, ST_VTX,
        ST_EDGE_RD, ST_EDGE_T, ST_EDGE_WB, ST_SINK_RD, ST_RESULT
    } state_t;

    // ---------------- input fields
    logic [dlpk_pkg::VERTEX_FIELD_W-1:0] s_from, s_to;
    logic [dlpk_pkg::WEIGHT_FIELD_W-1:0] s_weight;
    assign s_from   = s_tdata[9:0];
    assign s_to     = s_tdata[19:10];
    assign s_weight = s_tdata[35:20];

    // ---------------- configuration
    logic [dlpk_pkg::VCOUNT_W-1:0]       vcount_reg;
    logic [dlpk_pkg::VERTEX_FIELD_W-1:0] sink_reg;
    logic [NW-1:0]                       n_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= dlpk_pkg::VCOUNT_RESET;
            sink_reg   <= dlpk_pkg::SINK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dlpk_pkg::REG_VERTEX_COUNT: vcount_reg <= cfg_data;
                dlpk_pkg::REG_SINK_VERTEX:  sink_reg   <= cfg_data[9:0];
                default: ;  // unknown index: drop
            endcase
        end
    end

    // clamp vertex count to 1..MAX_VERTICES
    always_comb begin
        priority if (vcount_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(vcount_reg) > MAX_VERTICES) begin
            n_eff = NW'(MAX_VERTICES);
        end else begin
            n_eff = NW'(vcount_reg);
        end
    end

    logic          sink_ok;
    logic [VW-1:0] sink_addr;
    assign sink_ok   = sink_reg < n_eff;
    assign sink_addr = VW'(sink_reg);

    // ---------------- memories: ports and read registers
    logic [LW-1:0]          first_mem [MAX_VERTICES];
    logic [LW-1:0]          indeg_mem [MAX_VERTICES];
    logic [DW-1:0]          dist_mem  [MAX_VERTICES];
    logic [VW-1:0]          eto_mem   [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] ew_mem    [MAX_EDGES];
    logic [LW-1:0]          enext_mem [MAX_EDGES];

    logic [VW-1:0]          first_ra, first_wa, indeg_ra, indeg_wa, dist_ra, dist_wa;
    logic                   first_we, indeg_we, dist_we, edge_we;
    logic [LW-1:0]          first_wd, indeg_wd;
    logic [DW-1:0]          dist_wd;
    logic [EIW-1:0]         edge_ra, edge_wa;
    logic [LW-1:0]          first_q, indeg_q, enext_q;
    logic [DW-1:0]          dist_q;
    logic [VW-1:0]          eto_q;
    logic [WEIGHT_BITS-1:0] ew_q;

    always_ff @(posedge aclk) begin
        if (first_we) first_mem[first_wa] <= first_wd;
        if (indeg_we) indeg_mem[indeg_wa] <= indeg_wd;
        if (dist_we)  dist_mem[dist_wa]   <= dist_wd;
        first_q <= first_mem[first_ra];
        indeg_q <= indeg_mem[indeg_ra];
        dist_q  <= dist_mem[dist_ra];
    end

    // ---------------- ready queue
    dlpk_pkg::queue_ctrl_t q_ctrl;
    logic [VW-1:0]         q_push_data, q_rd_data;
    logic [NW-1:0]         q_head, q_tail;

    dlpk_queue #(
        .DEPTH (MAX_VERTICES)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (q_ctrl),
        .push_data (q_push_data),
        .rd_data   (q_rd_data),
        .head      (q_head),
        .tail      (q_tail)
    );

    // ---------------- sequencer registers
    state_t                 state_reg, state_next;
    logic [VW-1:0]          clr_reg, clr_next;
    logic [LW-1:0]          ecnt_reg, ecnt_next;
    logic [VW-1:0]          ld_from_reg, ld_from_next, ld_to_reg, ld_to_next;
    logic [WEIGHT_BITS-1:0] ld_w_reg, ld_w_next;
    logic                   ld_ok_reg, ld_ok_next, ld_last_reg, ld_last_next;
    logic [NW-1:0]          scan_reg, scan_next;
    logic                   scan_vld_reg, scan_vld_next;
    logic [VW-1:0]          scan_v_reg, scan_v_next;
    logic [LW-1:0]          link_reg, link_next;
    logic [DW-1:0]          du_reg, du_next, cand_reg, cand_next;
    logic [VW-1:0]          t_reg, t_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]          out_dist_reg, out_dist_next;
    logic                   out_cyc_reg, out_cyc_next;
    logic [dlpk_pkg::VISIT_W-1:0] out_vis_reg, out_vis_next;
    logic [SW-1:0]          cand_sum;

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            eto_mem[edge_wa]   <= ld_to_reg;
            ew_mem[edge_wa]    <= ld_w_reg;
            enext_mem[edge_wa] <= first_q;
        end
        eto_q   <= eto_mem[edge_ra];
        ew_q    <= ew_mem[edge_ra];
        enext_q <= enext_mem[edge_ra];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cand_sum = SW'(du_reg) + SW'(ew_q);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        ecnt_next     = ecnt_reg;
        ld_from_next  = ld_from_reg;
        ld_to_next    = ld_to_reg;
        ld_w_next     = ld_w_reg;
        ld_ok_next    = ld_ok_reg;
        ld_last_next  = ld_last_reg;
        scan_next     = scan_reg;
        scan_vld_next = 1'b0;
        scan_v_next   = scan_v_reg;
        link_next     = link_reg;
        du_next       = du_reg;
        cand_next     = cand_reg;
        t_next        = t_reg;
        out_dist_next = out_dist_reg;
        out_cyc_next  = out_cyc_reg;
        out_vis_next  = out_vis_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        first_ra = VW'(s_from);
        indeg_ra = VW'(s_to);
        dist_ra  = sink_addr;
        edge_ra  = EIW'(link_reg - LW'(1));
        first_we = 1'b0;
        indeg_we = 1'b0;
        dist_we  = 1'b0;
        edge_we  = 1'b0;
        first_wa = ld_from_reg;
        indeg_wa = ld_to_reg;
        dist_wa  = t_reg;
        first_wd = '0;
        indeg_wd = '0;
        dist_wd  = '0;
        edge_wa  = ecnt_reg[EIW-1:0];
        q_ctrl      = '0;
        q_push_data = t_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                first_we = 1'b1;
                indeg_we = 1'b1;
                dist_we  = 1'b1;
                first_wa = clr_reg;
                indeg_wa = clr_reg;
                dist_wa  = clr_reg;
                clr_next = clr_reg + VW'(1);
                if (clr_reg == VW'(MAX_VERTICES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    ld_from_next = VW'(s_from);
                    ld_to_next   = VW'(s_to);
                    ld_w_next    = WEIGHT_BITS'(s_weight);
                    ld_ok_next   = (s_from < n_eff) && (s_to < n_eff)
                                   && (ecnt_reg < LW'(MAX_EDGES));
                    ld_last_next = s_tlast;
                    state_next   = ST_LOAD_WR;
                end
            end
            ST_LOAD_WR: begin
                // push the edge onto the front of its source's list
                if (ld_ok_reg) begin
                    edge_we   = 1'b1;
                    first_we  = 1'b1;
                    first_wd  = ecnt_reg + LW'(1);
                    indeg_we  = 1'b1;
                    indeg_wd  = indeg_q + LW'(1);
                    ecnt_next = ecnt_reg + LW'(1);
                end
                scan_next = '0;
                state_next = ld_last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                indeg_ra      = VW'(scan_reg);
                scan_v_next   = VW'(scan_reg);
                scan_vld_next = scan_reg < n_eff;
                if (scan_reg < n_eff) begin
                    scan_next = scan_reg + NW'(1);
                end else if (!scan_vld_reg) begin
                    state_next = ST_POP;
                end
                if (scan_vld_reg && indeg_q == '0) begin
                    q_ctrl.push = 1'b1;
                    q_push_data = scan_v_reg;
                end
            end
            ST_POP: begin
                if (q_head < q_tail) begin
                    q_ctrl.pop = 1'b1;
                    state_next = ST_POP_WAIT;
                end else begin
                    state_next = ST_SINK_RD;
                end
            end
            ST_POP_WAIT: begin
                first_ra   = q_rd_data;
                dist_ra    = q_rd_data;
                state_next = ST_VTX;
            end
            ST_VTX: begin
                link_next  = first_q;
                du_next    = dist_q;
                state_next = (first_q != '0) ? ST_EDGE_RD : ST_POP;
            end
            ST_EDGE_RD: begin
                state_next = ST_EDGE_T;
            end
            ST_EDGE_T: begin
                dist_ra   = eto_q;
                indeg_ra  = eto_q;
                t_next    = eto_q;
                link_next = enext_q;
                cand_next = (cand_sum > SW'(dlpk_pkg::DIST_MAX)) ?
                            dlpk_pkg::DIST_MAX : DW'(cand_sum);
                state_next = ST_EDGE_WB;
            end
            ST_EDGE_WB: begin
                // relax the target, then drop its in-degree; skip stray targets
                if (t_reg < n_eff) begin
                    if (cand_reg > dist_q) begin
                        dist_we = 1'b1;
                        dist_wd = cand_reg;
                    end
                    if (indeg_q != '0) begin
                        indeg_we = 1'b1;
                        indeg_wa = t_reg;
                        indeg_wd = indeg_q - LW'(1);
                        if (indeg_q == LW'(1)) begin
                            q_ctrl.push = 1'b1;
                        end
                    end
                end
                state_next = (link_reg != '0) ? ST_EDGE_RD : ST_POP;
            end
            ST_SINK_RD: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_dist_next = sink_ok ? dist_q : '0;
                    out_cyc_next  = q_head < n_eff;
                    out_vis_next  = dlpk_pkg::VISIT_W'(q_head);
                    q_ctrl.clear  = 1'b1;
                    ecnt_next     = '0;
                    clr_next      = '0;
                    state_next    = ST_CLEAR;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            ecnt_reg     <= '0;
            scan_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            ecnt_reg     <= ecnt_next;
            scan_vld_reg <= scan_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ld_from_reg  <= ld_from_next;
        ld_to_reg    <= ld_to_next;
        ld_w_reg     <= ld_w_next;
        ld_ok_reg    <= ld_ok_next;
        ld_last_reg  <= ld_last_next;
        scan_reg     <= scan_next;
        scan_v_reg   <= scan_v_next;
        link_reg     <= link_next;
        du_reg       <= du_next;
        cand_reg     <= cand_next;
        t_reg        <= t_next;
        out_dist_reg <= out_dist_next;
        out_cyc_reg  <= out_cyc_next;
        out_vis_reg  <= out_vis_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_vis_reg, out_cyc_reg, out_dist_reg};

    // ---------------- checks
    `DLPK_CHECK(a_edge_count_bound, ecnt_reg <= LW'(MAX_EDGES), "edge count past capacity")
    `DLPK_CHECK(a_queue_order, q_head <= q_tail, "ready queue popped past its tail")
    `DLPK_CHECK_NEXT(a_result_then_clear, state_reg == ST_RESULT && (!m_tvalid_reg || m_tready),
        state_reg == ST_CLEAR && m_tvalid_reg, "result not followed by clearing pass")

endmodule
